FILE: hdl/pwb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pwb_pkg
// Shared types and constants of the posted write buffer: controller states
// and the command and status words between controller and datapath.
// ============================================================================
package pwb_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int RESULT_CNT_W = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_STORE,
        ST_READ,
        ST_EMIT,
        ST_FINISH
    } pwb_state_t;

    typedef struct packed {
        logic idle;
        logic store;
        logic read;
        logic emit;
        logic flush;
    } pwb_cmd_t;

    typedef struct packed {
        logic drain_item;
        logic write_done;
        logic full;
        logic empty;
        logic slot_last;
        logic emit_ok;
        logic flush_ok;
    } pwb_sts_t;

endpackage

FILE: hdl/pwb_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// pwb_ctrl
// Controller of the posted write buffer. Sequences chunk stores, slot reads,
// byte emission and the final flush of each item.
// ============================================================================
module pwb_ctrl
    import pwb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  pwb_sts_t sts,
    output pwb_cmd_t cmd
);

    pwb_state_t state_reg;
    pwb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (sts.drain_item)
                begin
                    state_next = sts.empty ? ST_FINISH : ST_READ;
                end
                else if (sts.write_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.full)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                state_next = ST_DECIDE;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.emit_ok && sts.slot_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_FINISH:
            begin
                if (sts.flush_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:   cmd.idle  = 1'b1;
            ST_DECIDE: cmd       = '0;
            ST_STORE:  cmd.store = 1'b1;
            ST_READ:   cmd.read  = 1'b1;
            ST_EMIT:   cmd.emit  = 1'b1;
            ST_FINISH: cmd.flush = 1'b1;
            default:   cmd       = '0;
        endcase
    end

endmodule

FILE: hdl/pwb_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// pwb_datapath
// Datapath of the posted write buffer: slot memory, pointers, item registers,
// drain byte counter, one held-back result and the output register.
// ============================================================================
module pwb_datapath
    import pwb_pkg::*;
#(
    parameter int ENTRIES         = 8,
    parameter int MAX_ENTRY_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pwb_cmd_t    cmd,
    output pwb_sts_t    sts,
    input  logic        in_valid,
    input  logic        command,
    input  logic [31:0] address,
    input  logic [3:0]  byte_count,
    input  logic [63:0] write_data,
    input  logic        cfg_valid,
    input  logic [3:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] bus_address,
    output logic [7:0]  bus_byte,
    output logic        last_of_run
);

    localparam int PTR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam int CNT_W  = $clog2(MAX_ENTRY_BYTES + 1);
    localparam int K_W    = (MAX_ENTRY_BYTES > 1) ? $clog2(MAX_ENTRY_BYTES) : 1;
    localparam int DATA_W = 8 * MAX_ENTRY_BYTES;
    localparam int SLOT_W = 32 + CNT_W + DATA_W;

    logic [SLOT_W-1:0] slot_mem [ENTRIES];
    logic [SLOT_W-1:0] rdata_reg;

    logic [3:0]        bpe_reg;
    logic              cmd_reg;
    logic [31:0]       addr_reg;
    logic [3:0]        remaining_reg;
    logic [63:0]       data_reg;

    logic [PTR_W-1:0]  fill_ptr_reg;
    logic [PTR_W-1:0]  drain_ptr_reg;
    logic [USED_W-1:0] used_reg;
    logic [K_W-1:0]    k_reg;
    logic [RESULT_CNT_W-1:0] emitted_reg;

    logic              pend_valid_reg;
    logic [31:0]       pend_addr_reg;
    logic [7:0]        pend_byte_reg;
    logic              out_valid_reg;
    logic [31:0]       out_addr_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic              load;
    logic              out_free;
    logic              can_count;
    logic              emit_fire;
    logic              slot_done;
    logic              flush_push;
    logic [3:0]        chunk_max;
    logic [3:0]        len;
    logic [DATA_W-1:0] chunk;
    logic [31:0]       rd_addr;
    logic [CNT_W-1:0]  rd_cnt;
    logic [DATA_W-1:0] rd_data;
    logic [31:0]       new_addr;
    logic [7:0]        new_byte;
    logic [PTR_W-1:0]  fill_ptr_next;
    logic [PTR_W-1:0]  drain_ptr_next;

    assign load      = cmd.idle && in_valid;
    assign out_free  = !out_valid_reg || !out_stall;
    assign can_count = emitted_reg < RESULT_CNT_W'(MAX_RESULTS);

    always_comb
    begin
        priority if (bpe_reg == 4'd0)
        begin
            chunk_max = 4'd1;
        end
        else if (bpe_reg > 4'(MAX_ENTRY_BYTES))
        begin
            chunk_max = 4'(MAX_ENTRY_BYTES);
        end
        else
        begin
            chunk_max = bpe_reg;
        end
    end

    assign len = (remaining_reg < chunk_max) ? remaining_reg : chunk_max;

    always_comb
    begin
        for (int j = 0; j < MAX_ENTRY_BYTES; j++)
        begin
            chunk[8*j +: 8] = (4'(j) < len) ? data_reg[8*j +: 8] : 8'h00;
        end
    end

    assign rd_data  = rdata_reg[DATA_W-1:0];
    assign rd_cnt   = rdata_reg[DATA_W +: CNT_W];
    assign rd_addr  = rdata_reg[DATA_W+CNT_W +: 32];
    assign new_addr = rd_addr + 32'(k_reg);
    assign new_byte = 8'(rd_data >> {k_reg, 3'b000});

    assign emit_fire  = cmd.emit && (!can_count || !pend_valid_reg || out_free);
    assign slot_done  = emit_fire && (5'(k_reg) + 5'd1 == 5'(rd_cnt));
    assign flush_push = cmd.flush && pend_valid_reg && out_free;

    assign fill_ptr_next  = (fill_ptr_reg == PTR_W'(ENTRIES - 1)) ? '0 : fill_ptr_reg + 1'b1;
    assign drain_ptr_next = (drain_ptr_reg == PTR_W'(ENTRIES - 1)) ? '0 : drain_ptr_reg + 1'b1;

    assign sts.drain_item = cmd_reg;
    assign sts.write_done = remaining_reg == 4'd0;
    assign sts.full       = used_reg == USED_W'(ENTRIES);
    assign sts.empty      = used_reg == '0;
    assign sts.slot_last  = 5'(k_reg) + 5'd1 == 5'(rd_cnt);
    assign sts.emit_ok    = emit_fire;
    assign sts.flush_ok   = !pend_valid_reg || out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            slot_mem[fill_ptr_reg] <= {addr_reg, CNT_W'(len), chunk};
        end
        if (cmd.read)
        begin
            rdata_reg <= slot_mem[drain_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg       <= command;
            addr_reg      <= address;
            remaining_reg <= (byte_count > 4'd8) ? 4'd8 : byte_count;
            data_reg      <= write_data;
        end
        else if (cmd.store)
        begin
            addr_reg      <= addr_reg + 32'(len);
            remaining_reg <= remaining_reg - len;
            data_reg      <= data_reg >> {len, 3'b000};
        end
        if (emit_fire && can_count)
        begin
            pend_addr_reg <= new_addr;
            pend_byte_reg <= new_byte;
        end
        if (emit_fire && can_count && pend_valid_reg)
        begin
            out_addr_reg <= pend_addr_reg;
            out_byte_reg <= pend_byte_reg;
            out_last_reg <= 1'b0;
        end
        else if (flush_push)
        begin
            out_addr_reg <= pend_addr_reg;
            out_byte_reg <= pend_byte_reg;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpe_reg        <= 4'd8;
            fill_ptr_reg   <= '0;
            drain_ptr_reg  <= '0;
            used_reg       <= '0;
            k_reg          <= '0;
            emitted_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bpe_reg <= cfg_data;
            end
            if (cmd.store)
            begin
                fill_ptr_reg <= fill_ptr_next;
            end
            if (slot_done)
            begin
                drain_ptr_reg <= drain_ptr_next;
            end
            if (cmd.store && !slot_done)
            begin
                used_reg <= used_reg + 1'b1;
            end
            else if (slot_done && !cmd.store)
            begin
                used_reg <= used_reg - 1'b1;
            end
            if (slot_done)
            begin
                k_reg <= '0;
            end
            else if (emit_fire)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (load)
            begin
                emitted_reg <= '0;
            end
            else if (emit_fire && can_count)
            begin
                emitted_reg <= emitted_reg + 1'b1;
            end
            if (emit_fire && can_count)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_push)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((emit_fire && can_count && pend_valid_reg) || flush_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign bus_address = out_addr_reg;
    assign bus_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(ENTRIES))
        else $error("slot usage exceeds the number of slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !sts.full)
        else $error("chunk stored into a full buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == '0 |-> fill_ptr_reg == drain_ptr_reg)
        else $error("pointers disagree on an empty buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        flush_push |=> out_valid_reg && out_last_reg && !pend_valid_reg)
        else $error("final word of a run not presented with its last flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= RESULT_CNT_W'(MAX_RESULTS))
        else $error("result count per item exceeds its limit");

endmodule

FILE: hdl/posted_write_buffer.sv
`timescale 1ns / 1ps
// ============================================================================
// posted_write_buffer
// Circular buffer of posted byte writes that drains to the bus one byte per
// word, oldest slot first.
// ============================================================================
// Items are taken one at a time. The input is stalled except in the idle
// state, where a word is taken. A write item then passes through a decision
// state and a store state for each stored chunk. When the buffer is full, each
// chunk is preceded by a drain of the oldest slot: a decision state, a memory
// read state and the emission of each byte in that slot. A drain item does the
// same for every used slot. Every item ends with a decision state and a flush
// state. The last word of each run is held back in a pending register so that
// its last_of_run flag can be set; output stall holds back the byte emission
// and the flush.
module posted_write_buffer
    import pwb_pkg::*;
#(
    parameter int ENTRIES         = 8,
    parameter int MAX_ENTRY_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] address,
    input  logic [3:0]  byte_count,
    input  logic [63:0] write_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] bus_address,
    output logic [7:0]  bus_byte,
    output logic        last_of_run
);

    pwb_cmd_t cmd;
    pwb_sts_t sts;

    assign in_stall  = !cmd.idle;
    assign cfg_ready = 1'b1;

    pwb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    pwb_datapath #(
        .ENTRIES         (ENTRIES),
        .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_valid    (in_valid),
        .command     (command),
        .address     (address),
        .byte_count  (byte_count),
        .write_data  (write_data),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bus_address (bus_address),
        .bus_byte    (bus_byte),
        .last_of_run (last_of_run)
    );

endmodule

FILE: dv/pwb_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pwb_tb_pkg
// Command codes of the posted write buffer, shared by the checker and the
// stimulus side of the testbench.
// ============================================================================
package pwb_tb_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

endpackage

FILE: dv/posted_write_buffer_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// posted_write_buffer_chk
// Passive checker of the posted write buffer. It watches the input, the
// configuration and the bus channels, keeps its own image of the slots, the
// pointers and the slot size, predicts the bus byte writes of every accepted
// word and compares each accepted bus word, field by field, with the oldest
// prediction. It hands its mismatch count and the number of outstanding bus
// writes to the testbench top.
// ============================================================================
module posted_write_buffer_chk
    import pwb_pkg::*;
    import pwb_tb_pkg::*;
#(
    parameter int ENTRIES         = 8,
    parameter int MAX_ENTRY_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [31:0] address,
    input  logic [3:0]  byte_count,
    input  logic [63:0] write_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] bus_address,
    input  logic [7:0]  bus_byte,
    input  logic        last_of_run,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [31:0] addr;
        logic [7:0]  data;
        logic        last;
    } bus_write_t;

    bus_write_t  bus_writes_due[$];
    bus_write_t  run_writes[$];
    logic [31:0] slot_addr  [ENTRIES];
    logic [3:0]  slot_len   [ENTRIES];
    logic [63:0] slot_bytes [ENTRIES];
    int          fill_idx;
    int          drain_idx;
    int          slots_used;
    logic [3:0]  entry_size;

    task automatic report(input string msg);
        if (fail_count < 40)
            $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic post_byte(input logic [31:0] a, input logic [7:0] b);
        bus_write_t w;
        if (run_writes.size() < MAX_RESULTS)
        begin
            w.addr = a;
            w.data = b;
            w.last = 1'b0;
            run_writes.push_back(w);
        end
    endtask

    task automatic retire_oldest_slot();
        logic [31:0] a;
        a = slot_addr[drain_idx];
        for (int k = 0; k < int'(slot_len[drain_idx]); k++)
        begin
            post_byte(a, slot_bytes[drain_idx][8*k +: 8]);
            a = a + 32'd1;
        end
        drain_idx = (drain_idx + 1) % ENTRIES;
        slots_used--;
    endtask

    task automatic predict_word(input logic cmd, input logic [31:0] addr_in,
                                input logic [3:0] cnt, input logic [63:0] data);
        int          limit;
        int          left;
        int          len;
        int          offset;
        logic [31:0] a;
        logic [63:0] chunk;
        run_writes.delete();
        a = addr_in;
        limit = (entry_size == 4'd0) ? 1 : int'(entry_size);
        if (limit > MAX_ENTRY_BYTES)
            limit = MAX_ENTRY_BYTES;
        if (limit > 8)
            limit = 8;
        if (cmd == CMD_DRAIN)
        begin
            while (slots_used > 0)
                retire_oldest_slot();
        end
        else
        begin
            left = (cnt > 4'd8) ? 8 : int'(cnt);
            offset = 0;
            while (left > 0)
            begin
                len = (left < limit) ? left : limit;
                if (slots_used >= ENTRIES)
                    retire_oldest_slot();
                chunk = data >> (8 * offset);
                if (len < 8)
                    chunk = chunk & ((64'd1 << (8 * len)) - 64'd1);
                slot_addr[fill_idx] = a;
                slot_len[fill_idx] = 4'(len);
                slot_bytes[fill_idx] = chunk;
                a = a + 32'(len);
                offset += len;
                left -= len;
                fill_idx = (fill_idx + 1) % ENTRIES;
                slots_used++;
            end
        end
        if (run_writes.size() > 0)
            run_writes[run_writes.size() - 1].last = 1'b1;
        foreach (run_writes[i])
            bus_writes_due.push_back(run_writes[i]);
    endtask

    task automatic check_bus_word();
        bus_write_t want;
        if (bus_writes_due.size() == 0)
        begin
            report($sformatf("unexpected bus write addr %h byte %h last %b",
                             bus_address, bus_byte, last_of_run));
        end
        else
        begin
            want = bus_writes_due.pop_front();
            if (bus_address !== want.addr)
                report($sformatf("bus_address %h, expected %h", bus_address, want.addr));
            if (bus_byte !== want.data)
                report($sformatf("bus_byte %h at %h, expected %h",
                                 bus_byte, want.addr, want.data));
            if (last_of_run !== want.last)
                report($sformatf("last_of_run %b at %h, expected %b",
                                 last_of_run, want.addr, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_writes_due.delete();
            fill_idx = 0;
            drain_idx = 0;
            slots_used = 0;
            entry_size = 4'd8;
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                entry_size = cfg_data;
            if (in_valid && !in_stall)
                predict_word(command, address, byte_count, write_data);
            if (out_valid && !out_stall)
                check_bus_word();
            pending <= bus_writes_due.size();
        end
    end

endmodule

FILE: dv/posted_write_buffer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// posted_write_buffer_tb
// Testbench top of the posted write buffer. It drives directed and random
// write and drain words with random gaps, stalls the bus side at random and
// once for a long stretch, changes the slot size between phases while the
// block is idle, and gives the verdict from the checker's mismatch count.
// ============================================================================
module posted_write_buffer_tb;
    import pwb_pkg::*;
    import pwb_tb_pkg::*;

    localparam int ENTRIES         = 8;
    localparam int MAX_ENTRY_BYTES = 8;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_WORDS    = 320;
    localparam int PHASES          = 12;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = CMD_WRITE;
    logic [31:0] address = '0;
    logic [3:0]  byte_count = '0;
    logic [63:0] write_data = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] bus_address;
    logic [7:0]  bus_byte;
    logic        last_of_run;

    logic        rx_stall = 1'b0;
    logic        hold_stall = 1'b0;
    logic        hold_req = 1'b0;
    logic        quiet = 1'b0;
    int          fail_count;
    int          pending;
    int          words_sent = 0;
    logic [31:0] next_addr = 32'h0000_1000;

    assign out_stall = rx_stall | hold_stall;

    posted_write_buffer #(
        .ENTRIES         (ENTRIES),
        .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .address     (address),
        .byte_count  (byte_count),
        .write_data  (write_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bus_address (bus_address),
        .bus_byte    (bus_byte),
        .last_of_run (last_of_run)
    );

    posted_write_buffer_chk #(
        .ENTRIES         (ENTRIES),
        .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .address     (address),
        .byte_count  (byte_count),
        .write_data  (write_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bus_address (bus_address),
        .bus_byte    (bus_byte),
        .last_of_run (last_of_run),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("posted_write_buffer test failed");
        $finish;
    end

    function automatic int idle_gap();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic send_word(input logic cmd, input logic [31:0] a,
                             input logic [3:0] cnt, input logic [63:0] d);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        address    <= a;
        byte_count <= cnt;
        write_data <= d;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || in_stall)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_size(input logic [3:0] size);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_word(input int drain_pct);
        logic [31:0] a;
        logic [3:0]  cnt;
        logic [63:0] d;
        int          pick;
        d = {$urandom, $urandom};
        if ($urandom_range(0, 99) < drain_pct)
        begin
            send_word(CMD_DRAIN, $urandom, 4'($urandom), d);
            words_sent++;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                cnt = 4'd0;
            else if (pick < 15)
                cnt = 4'($urandom_range(9, 15));
            else
                cnt = 4'($urandom_range(1, 8));
            pick = $urandom_range(0, 99);
            if (pick < 10)
                a = 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
            else if (pick < 45)
                a = next_addr;
            else
                a = $urandom;
            send_word(CMD_WRITE, a, cnt, d);
            next_addr = a + ((cnt > 4'd8) ? 32'd8 : 32'(cnt));
            if (cnt != 4'd0)
                words_sent++;
        end
    endtask

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = idle_gap();
            if (gap > 0)
            begin
                rx_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rx_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_stall <= 1'b0;
    end

    initial
    begin
        logic [3:0] sizes [PHASES];
        int         drain_pct;
        sizes = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd9, 4'd7, 4'd4, 4'd6, 4'd1};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_entry_size(4'd8);
        send_word(CMD_WRITE, 32'h0000_1000, 4'd0, 64'hDEAD_BEEF_DEAD_BEEF);
        send_word(CMD_DRAIN, 32'h0, 4'd0, 64'h0);
        send_word(CMD_WRITE, 32'h0000_0000, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_WRITE, 32'hFFFF_FFFE, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_word(CMD_WRITE, 32'h1234_5678, 4'd15, {$urandom, $urandom});
        send_word(CMD_WRITE, 32'h0000_2000, 4'd8, 64'h0);
        send_word(CMD_WRITE, 32'h0000_3000, 4'd7, {$urandom, $urandom});
        send_word(CMD_WRITE, 32'h0000_4000, 4'd2, {$urandom, $urandom});
        send_word(CMD_WRITE, 32'h0000_5000, 4'd8, {$urandom, $urandom});
        send_word(CMD_WRITE, 32'h0000_6000, 4'd8, {$urandom, $urandom});
        send_word(CMD_WRITE, 32'h0000_7000, 4'd8, {$urandom, $urandom});
        send_word(CMD_WRITE, 32'h0000_8000, 4'd5, {$urandom, $urandom});
        send_word(CMD_DRAIN, 32'hFFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        set_entry_size(4'd1);
        send_word(CMD_WRITE, 32'hFFFF_FFFC, 4'd8, {$urandom, $urandom});
        send_word(CMD_WRITE, 32'h0000_9000, 4'd8, {$urandom, $urandom});
        set_entry_size(4'd15);
        send_word(CMD_WRITE, 32'h0000_A000, 4'd15, {$urandom, $urandom});
        set_entry_size(4'd0);
        send_word(CMD_WRITE, 32'h0000_B000, 4'd3, {$urandom, $urandom});
        set_entry_size(4'd4);
        send_word(CMD_DRAIN, 32'h0, 4'd0, 64'h0);
        send_word(CMD_WRITE, 32'hFFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_WRITE, 32'h0000_0000, 4'd9, 64'h0);
        send_word(CMD_DRAIN, 32'h0, 4'd0, 64'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            set_entry_size(sizes[p]);
            quiet = ($urandom_range(0, 3) == 0);
            drain_pct = $urandom_range(3, 25);
            if (p == 3)
            begin
                quiet = 1'b1;
                drain_pct = 2;
                hold_req = 1'b1;
            end
            while (words_sent < RANDOM_WORDS * (p + 1) / PHASES)
                random_word(drain_pct);
        end

        send_word(CMD_DRAIN, 32'h0, 4'd0, 64'h0);
        settle();
        if (fail_count == 0)
            $display("posted_write_buffer test passed");
        else
            $display("posted_write_buffer test failed");
        $finish;
    end

endmodule
